### sv/cft_pkg.sv
// Package for the CSV field tokenizer: word types, character constants
// and parser state encoding. No dependencies.
`default_nettype none

package cft_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR = 8'd34;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'd9;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;
    localparam logic [CHAR_W-1:0] SEP_RESET  = 8'd44;

    typedef struct packed {
        logic              end_of_line;
        logic [CHAR_W-1:0] in_char;
    } item_t;

    typedef struct packed {
        logic              line_end;
        logic              field_end;
        logic              char_valid;
        logic [CHAR_W-1:0] out_char;
    } result_t;

    typedef enum logic [5:0] {
        ST_START  = 6'b000001,
        ST_SEPS   = 6'b000010,
        ST_UNQ    = 6'b000100,
        ST_QUOTED = 6'b001000,
        ST_QCLOSE = 6'b010000,
        ST_DONE   = 6'b100000
    } parse_state_t;

endpackage

`default_nettype wire

### sv/cft_in_stage.sv
// Input register for the CSV field tokenizer: holds one accepted word.
// Depends on cft_pkg.
`default_nettype none

module cft_in_stage
    import cft_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       item_valid,
    input  wire logic  item_ready,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

### sv/cft_parse.sv
// Parser state machine and result register of the CSV field tokenizer.
// Depends on cft_pkg.
`default_nettype none

module cft_parse
    import cft_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CHAR_W-1:0] separator,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire item_t             item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;
    logic         take;
    logic         emit;
    result_t      step_res;
    logic [CHAR_W-1:0] c;
    logic         open;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    assign c    = (item.in_char == TAB_CHAR) ? SPACE_CHAR : item.in_char;
    assign open = state_reg inside {ST_UNQ, ST_QUOTED, ST_QCLOSE};

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        step_res   = '0;
        if (item.end_of_line)
        begin
            state_next         = ST_START;
            emit               = 1'b1;
            step_res.field_end = open;
            step_res.line_end  = 1'b1;
        end
        else if (state_reg == ST_DONE)
        begin
            state_next = ST_DONE;
        end
        else if (c == NUL_CHAR)
        begin
            state_next         = ST_DONE;
            emit               = open;
            step_res.field_end = open;
        end
        else
        begin
            case (state_reg)
                ST_SEPS:
                begin
                    if (c == separator)
                    begin
                        state_next = ST_SEPS;
                    end
                    else if (c == QUOTE_CHAR)
                    begin
                        state_next = ST_QUOTED;
                    end
                    else
                    begin
                        state_next          = ST_UNQ;
                        emit                = 1'b1;
                        step_res.out_char   = c;
                        step_res.char_valid = 1'b1;
                    end
                end
                ST_UNQ:
                begin
                    emit = 1'b1;
                    if (c == separator)
                    begin
                        state_next         = ST_SEPS;
                        step_res.field_end = 1'b1;
                    end
                    else
                    begin
                        state_next          = ST_UNQ;
                        step_res.out_char   = c;
                        step_res.char_valid = 1'b1;
                    end
                end
                ST_QUOTED:
                begin
                    if (c == QUOTE_CHAR)
                    begin
                        state_next = ST_QCLOSE;
                    end
                    else
                    begin
                        state_next          = ST_QUOTED;
                        emit                = 1'b1;
                        step_res.out_char   = c;
                        step_res.char_valid = 1'b1;
                    end
                end
                ST_QCLOSE:
                begin
                    emit = 1'b1;
                    if (c == QUOTE_CHAR)
                    begin
                        // doubled quote inside a quoted field
                        state_next          = ST_QUOTED;
                        step_res.out_char   = QUOTE_CHAR;
                        step_res.char_valid = 1'b1;
                    end
                    else
                    begin
                        // char after the closing quote is dropped
                        state_next         = ST_START;
                        step_res.field_end = 1'b1;
                    end
                end
                default:
                begin
                    if (c == QUOTE_CHAR)
                    begin
                        state_next = ST_QUOTED;
                    end
                    else if (c == separator)
                    begin
                        state_next         = ST_SEPS;
                        emit               = 1'b1;
                        step_res.field_end = 1'b1;
                    end
                    else
                    begin
                        state_next          = ST_UNQ;
                        emit                = 1'b1;
                        step_res.out_char   = c;
                        step_res.char_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= step_res;
        end
    end

`ifndef ASSERT_OFF
    a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_line |=> state_reg == ST_START && out_valid_reg && res.line_end)
        else $error("end of line did not restart the parser");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item.end_of_line && state_reg == ST_DONE |=> state_reg == ST_DONE)
        else $error("ignored tail of line left the done state");

    a_char_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res.char_valid |-> !res.field_end && !res.line_end)
        else $error("character word also flags an end");

    a_nochar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.char_valid |-> res.out_char == NUL_CHAR)
        else $error("mark word carries a character");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |-> !take)
        else $error("item consumed while result register is full");
`endif

endmodule

`default_nettype wire

### sv/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: separator register, input stage
// and parser. Depends on cft_pkg, cft_in_stage and cft_parse.
//
//   channel   dir  tdata          tuser                        tlast
//   s_axis    in   in_char[7:0]   -                            end_of_line
//   m_axis    out  out_char[7:0]  [0] char_valid [1] field_end line_end
//   cfg       in   separator[7:0] (valid/ready write, no address)
//
// One word per cycle sustained while m_axis accepts; each word passes input register
// -> parser state update -> result register on its way to m_axis.
// Words that produce no result are consumed without an output word.
// Reset (rst_n low, async) returns the parser to line start, separator to ','.
// A stalled m_axis holds the result and blocks the parser; the input register
// takes one more word while empty, then s_axis stalls too.
`default_nettype none

module csv_field_tokenizer_top
    import cft_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [CHAR_W-1:0] s_axis_tdata,   // in_char
    input  wire logic              s_axis_tlast,   // end_of_line
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [CHAR_W-1:0]      m_axis_tdata,   // out_char
    output logic [1:0]             m_axis_tuser,   // char_valid, field_end
    output logic                   m_axis_tlast,   // line_end
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CHAR_W-1:0] cfg_data        // separator
);

    logic [CHAR_W-1:0] separator_reg;
    item_t             in_item;
    item_t             item;
    logic              item_valid;
    logic              item_ready;
    result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            separator_reg <= cfg_data;
        end
    end

    assign in_item.in_char     = s_axis_tdata;
    assign in_item.end_of_line = s_axis_tlast;

    cft_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    cft_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .separator  (separator_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = res.out_char;
    assign m_axis_tuser = {res.field_end, res.char_valid};
    assign m_axis_tlast = res.line_end;

endmodule

`default_nettype wire

### tb/csv_field_tokenizer_top_tb.sv
// Testbench for csv_field_tokenizer_top: streams CSV lines under several separators,
// predicts each output word with a local parser model and compares in order.
// Depends on cft_pkg and the csv_field_tokenizer_top RTL.
`default_nettype none

module csv_field_tokenizer_top_tb;
    import cft_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 130;
    localparam int DRAIN_CYCLES = 8;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata  = '0;    // in_char
    logic              s_axis_tlast  = 1'b0;  // end_of_line
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CHAR_W-1:0] m_axis_tdata;          // out_char
    logic [1:0]        m_axis_tuser;          // [0] char_valid, [1] field_end
    logic              m_axis_tlast;          // line_end
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [CHAR_W-1:0] cfg_data      = '0;    // separator

    item_t        char_queue[$];
    result_t      token_queue[$];
    item_t        next_word;
    result_t      want_token;
    parse_state_t tok_state  = ST_START;
    logic [7:0]   field_sep  = SEP_RESET;
    int           errors     = 0;
    int           cycle_cnt  = 0;
    int           phase_words;
    int           in_gap     = 0;
    int           out_stall  = 0;
    bit           in_quiet   = 1'b0;
    bit           out_quiet  = 1'b0;
    logic [7:0]   sep_list[7];

    csv_field_tokenizer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = int'($urandom_range(0, 99));
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_cnt);
        errors++;
    endtask

    task automatic tokenize_word(input logic [7:0] ch_in, input logic eol);
        logic [7:0] c;
        logic       open;
        result_t    r;
        bit         emit;
        c    = ch_in;
        r    = '0;
        emit = 1'b0;
        open = tok_state inside {ST_UNQ, ST_QUOTED, ST_QCLOSE};
        if (eol)
        begin
            tok_state   = ST_START;
            r.field_end = open;
            r.line_end  = 1'b1;
            emit        = 1'b1;
        end
        else
        begin
            if (c == TAB_CHAR)
                c = SPACE_CHAR;
            if (tok_state == ST_DONE)
                emit = 1'b0;
            else if (c == NUL_CHAR)
            begin
                tok_state   = ST_DONE;
                r.field_end = open;
                emit        = open;
            end
            else
            begin
                case (tok_state)
                    ST_SEPS:
                        if (c == QUOTE_CHAR && c != field_sep)
                            tok_state = ST_QUOTED;
                        else if (c != field_sep)
                        begin
                            tok_state = ST_UNQ;
                            r.out_char = c; r.char_valid = 1'b1; emit = 1'b1;
                        end
                    ST_UNQ:
                        if (c == field_sep)
                        begin
                            tok_state = ST_SEPS;
                            r.field_end = 1'b1; emit = 1'b1;
                        end
                        else
                        begin
                            r.out_char = c; r.char_valid = 1'b1; emit = 1'b1;
                        end
                    ST_QUOTED:
                        if (c == QUOTE_CHAR)
                            tok_state = ST_QCLOSE;
                        else
                        begin
                            r.out_char = c; r.char_valid = 1'b1; emit = 1'b1;
                        end
                    ST_QCLOSE:
                        if (c == QUOTE_CHAR)
                        begin
                            tok_state = ST_QUOTED;
                            r.out_char = QUOTE_CHAR; r.char_valid = 1'b1; emit = 1'b1;
                        end
                        else
                        begin
                            tok_state = ST_START;
                            r.field_end = 1'b1; emit = 1'b1;
                        end
                    default:
                        if (c == QUOTE_CHAR)
                            tok_state = ST_QUOTED;
                        else if (c == field_sep)
                        begin
                            tok_state = ST_SEPS;
                            r.field_end = 1'b1; emit = 1'b1;
                        end
                        else
                        begin
                            tok_state = ST_UNQ;
                            r.out_char = c; r.char_valid = 1'b1; emit = 1'b1;
                        end
                endcase
            end
        end
        if (emit)
            token_queue.push_back(r);
    endtask

    task automatic queue_word(input logic [7:0] c, input logic eol);
        item_t w;
        w.in_char     = c;
        w.end_of_line = eol;
        char_queue.push_back(w);
        phase_words++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_word(s[i], 1'b0);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            return TAB_CHAR;
        do
            c = 8'($urandom_range(1, 255));
        while (c == field_sep || c == QUOTE_CHAR);
        return c;
    endfunction

    task automatic add_random_line();
        int nf;
        int len;
        int kind;
        int r;
        nf = $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0)
            queue_word(field_sep, 1'b0);
        for (int f = 0; f < nf; f++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                len = $urandom_range(1, 6);
                repeat (len) queue_word(plain_char(), 1'b0);
            end
            else if (kind < 8)
            begin
                queue_word(QUOTE_CHAR, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 20)
                    begin
                        queue_word(QUOTE_CHAR, 1'b0);
                        queue_word(QUOTE_CHAR, 1'b0);
                    end
                    else if (r < 35)
                        queue_word(field_sep, 1'b0);
                    else
                        queue_word(plain_char(), 1'b0);
                end
                if ($urandom_range(0, 7) != 0)
                    queue_word(QUOTE_CHAR, 1'b0);
            end
            else if (kind == 9)
            begin
                len = $urandom_range(1, 4);
                repeat (len) queue_word(8'($urandom_range(0, 255)), 1'b0);
            end
            if (f < nf - 1)
            begin
                queue_word(field_sep, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) queue_word(field_sep, 1'b0);
            end
        end
        if ($urandom_range(0, 5) == 0)
            queue_word(field_sep, 1'b0);
        if ($urandom_range(0, 15) == 0)
        begin
            queue_word(NUL_CHAR, 1'b0);
            repeat ($urandom_range(0, 4)) queue_word(8'($urandom_range(0, 255)), 1'b0);
        end
        queue_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        while (char_queue.size() > 0 || s_axis_tvalid || token_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        field_sep = value;
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                tokenize_word(s_axis_tdata, s_axis_tlast);
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (char_queue.size() > 0)
            begin
                next_word = char_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_word.in_char;
                s_axis_tlast  <= next_word.end_of_line;
                if ($urandom_range(0, 49) == 0)
                    in_quiet = !in_quiet;
                in_gap = pick_gap(in_quiet);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (token_queue.size() == 0)
                    report_mismatch("unexpected word, out_char", m_axis_tdata, 8'h00);
                else
                begin
                    want_token = token_queue.pop_front();
                    if (m_axis_tdata !== want_token.out_char)
                        report_mismatch("out_char", m_axis_tdata, want_token.out_char);
                    if (m_axis_tuser[0] !== want_token.char_valid)
                        report_mismatch("char_valid", {7'd0, m_axis_tuser[0]},
                                        {7'd0, want_token.char_valid});
                    if (m_axis_tuser[1] !== want_token.field_end)
                        report_mismatch("field_end", {7'd0, m_axis_tuser[1]},
                                        {7'd0, want_token.field_end});
                    if (m_axis_tlast !== want_token.line_end)
                        report_mismatch("line_end", {7'd0, m_axis_tlast},
                                        {7'd0, want_token.line_end});
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    out_quiet = !out_quiet;
                out_stall = pick_gap(out_quiet);
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sep_list = '{8'd255, 8'd0, QUOTE_CHAR, SPACE_CHAR, TAB_CHAR, 8'd0, SEP_RESET};
        sep_list[5] = 8'($urandom_range(0, 255));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        phase_words = 0;
        queue_word(8'hA5, 1'b1);
        queue_text(",a\t");
        queue_word(8'h00, 1'b1);
        queue_text("b,,");
        queue_word(8'hFF, 1'b0);
        queue_text(",");
        queue_word(8'h5A, 1'b1);
        queue_text("\"x\"\"y\"");
        queue_word(8'h00, 1'b1);
        queue_text("\"z\",w");
        queue_word(NUL_CHAR, 1'b0);
        queue_text("k");
        queue_word(8'hFF, 1'b1);
        while (phase_words < PHASE_WORDS)
            add_random_line();
        wait_idle();

        foreach (sep_list[p])
        begin
            write_separator(sep_list[p]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
                add_random_line();
            wait_idle();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/cft_pkg.sv
sv/cft_in_stage.sv
sv/cft_parse.sv
sv/csv_field_tokenizer_top.sv
tb/csv_field_tokenizer_top_tb.sv
